// ===== rtl/huffman_code_bit_packer_macros.svh =====
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    // Fixed field widths.
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Bit accumulator: up to seven pending bits plus one full code.
    localparam int ACC_W       = 40;
    localparam int ACC_CNT_W   = 6;

    // Operation codes of an input transfer.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    typedef enum logic [1:0] {
        CMD_ENC = 2'd0,
        CMD_FIN = 2'd1,
        CMD_ERR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_pad_count;
        logic       last_of_run;
        logic       length_error;
    } out_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/hcbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/hcbp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbp_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire hcbp_pkg::cmd_t              wr_cmd,
    input  wire logic                        pop,
    output hcbp_pkg::cmd_t                   head,
    output logic [hcbp_pkg::QCNT_W-1:0]      count
);

    hcbp_pkg::cmd_t                    mem_reg [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [hcbp_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [hcbp_pkg::QCNT_W-1:0]       count_reg, count_next;

    // Pointer and occupancy update; the depth is a power of two so pointers wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries carry payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/hcbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbp_front #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        op_valid,
    output logic                             op_stall,
    input  wire hcbp_pkg::in_item_t          op_item,
    input  wire logic [hcbp_pkg::QCNT_W-1:0] q_count,
    output logic                             q_push,
    output hcbp_pkg::cmd_t                   q_cmd
);

    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                 : hcbp_pkg::CODE_W;
    localparam int OCC_W     = hcbp_pkg::QCNT_W + 1;

    logic                              accept;
    logic                              in_range;
    logic                              len_bad;
    logic                              is_load, is_enc, is_fin;
    logic [ADDR_W-1:0]                 addr;
    logic [hcbp_pkg::CODE_W:0]         mask_wide;
    logic                              wr_en, rd_en;
    hcbp_pkg::entry_t                  wr_entry;
    hcbp_pkg::entry_t                  rd_entry;
    logic [OCC_W-1:0]                  occupancy;

    logic                              s1_valid_reg, s1_valid_next;
    hcbp_pkg::cmd_kind_t               s1_kind_reg, s1_kind_next;
    logic                              s1_hit_reg, s1_hit_next;
    logic [SYMBOL_COUNT-1:0]           vld_reg, vld_next;

    // Credit check: every item in flight must find a queue slot.
    assign occupancy = OCC_W'(q_count) + OCC_W'(s1_valid_reg);
    assign op_stall  = (occupancy >= OCC_W'(hcbp_pkg::QUEUE_DEPTH));
    assign accept    = op_valid && !op_stall;

    // Classify the incoming transfer.
    always_comb
    begin
        addr      = op_item.symbol[ADDR_W-1:0];
        in_range  = ({1'b0, op_item.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
        len_bad   = ({1'b0, op_item.code_length} > (hcbp_pkg::LEN_W + 1)'(LEN_LIMIT));
        is_load   = (op_item.operation == hcbp_pkg::OP_LOAD);
        is_enc    = (op_item.operation == hcbp_pkg::OP_ENCODE);
        is_fin    = (op_item.operation == hcbp_pkg::OP_FINISH);
        mask_wide = ~({(hcbp_pkg::CODE_W + 1){1'b1}} << op_item.code_length);

        wr_en          = accept && is_load && !len_bad && in_range;
        rd_en          = accept && is_enc;
        wr_entry.code  = op_item.code_bits & mask_wide[hcbp_pkg::CODE_W-1:0];
        wr_entry.len   = op_item.code_length;

        s1_valid_next = accept && ((is_load && len_bad) || is_enc || is_fin);
        if (is_load)
        begin
            s1_kind_next = hcbp_pkg::CMD_ERR;
        end
        else if (is_enc)
        begin
            s1_kind_next = hcbp_pkg::CMD_ENC;
        end
        else
        begin
            s1_kind_next = hcbp_pkg::CMD_FIN;
        end
        s1_hit_next = in_range && vld_reg[addr];

        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[addr] = 1'b1;
        end
    end

    // Code table; entries without a valid bit read as unused.
    hcbp_ram #(
        .WIDTH ($bits(hcbp_pkg::entry_t)),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= hcbp_pkg::CMD_FIN;
            s1_hit_reg   <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_kind_reg  <= s1_kind_next;
            s1_hit_reg   <= s1_hit_next;
            vld_reg      <= vld_next;
        end
    end

    // Forward the command once the table data has arrived; unused symbols drop out.
    always_comb
    begin
        q_push = s1_valid_reg
                 && ((s1_kind_reg != hcbp_pkg::CMD_ENC)
                     || (s1_hit_reg && (rd_entry.len != '0)));
        q_cmd.kind = s1_kind_reg;
        q_cmd.code = rd_entry.code;
        q_cmd.len  = rd_entry.len;
    end

endmodule

`default_nettype wire

// ===== rtl/hcbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [hcbp_pkg::QCNT_W-1:0] q_count,
    input  wire hcbp_pkg::cmd_t              q_head,
    output logic                             q_pop,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output hcbp_pkg::out_item_t              res_item
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BYTES = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_ERR   = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [hcbp_pkg::ACC_W-1:0]         sh_reg, sh_next;
    logic [hcbp_pkg::ACC_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [3:0]                         pad_reg, pad_next;
    logic                               fin_reg, fin_next;
    logic                               res_valid_reg, res_valid_next;
    hcbp_pkg::out_item_t                res_item_reg, res_item_next;

    logic                               out_free;
    logic [hcbp_pkg::ACC_W-1:0]         code_al;
    logic [hcbp_pkg::ACC_W-1:0]         placed;
    logic [hcbp_pkg::ACC_CNT_W-1:0]     cnt_sum;
    logic [hcbp_pkg::ACC_CNT_W-1:0]     rem;
    logic                               rem_small;

    // Append path: left-align the code, then place it after the pending bits.
    always_comb
    begin
        code_al   = {q_head.code, 8'h00} << (hcbp_pkg::ACC_CNT_W'(hcbp_pkg::CODE_W)
                                             - q_head.len);
        placed    = code_al >> cnt_reg[2:0];
        cnt_sum   = cnt_reg + q_head.len;
        rem       = cnt_reg - hcbp_pkg::ACC_CNT_W'(8);
        rem_small = (rem < hcbp_pkg::ACC_CNT_W'(8));
    end

    // Command sequencer: one command taken, then one result per free output slot.
    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        fin_next       = fin_reg;
        out_free       = !res_valid_reg || !res_stall;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_count != '0)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        hcbp_pkg::CMD_ENC:
                        begin
                            sh_next  = sh_reg | placed;
                            cnt_next = cnt_sum;
                            if (cnt_sum >= hcbp_pkg::ACC_CNT_W'(8))
                            begin
                                state_next = ST_BYTES;
                            end
                        end
                        hcbp_pkg::CMD_FIN:
                        begin
                            if (cnt_reg != '0)
                            begin
                                pad_next   = 4'd8 - {1'b0, cnt_reg[2:0]};
                                cnt_next   = hcbp_pkg::ACC_CNT_W'(8);
                                fin_next   = 1'b1;
                                state_next = ST_BYTES;
                            end
                            else
                            begin
                                pad_next   = 4'd0;
                                state_next = ST_PAD;
                            end
                        end
                        hcbp_pkg::CMD_ERR:
                        begin
                            state_next = ST_ERR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BYTES:
            begin
                if (out_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.data_byte    = sh_reg[hcbp_pkg::ACC_W-1 -: 8];
                    res_item_next.is_pad_count = 1'b0;
                    res_item_next.last_of_run  = rem_small && !fin_reg;
                    res_item_next.length_error = 1'b0;
                    sh_next                    = sh_reg << 8;
                    cnt_next                   = rem;
                    if (rem_small)
                    begin
                        state_next = fin_reg ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.data_byte    = {4'd0, pad_reg};
                    res_item_next.is_pad_count = 1'b1;
                    res_item_next.last_of_run  = 1'b1;
                    res_item_next.length_error = 1'b0;
                    sh_next                    = '0;
                    cnt_next                   = '0;
                    fin_next                   = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.data_byte    = 8'd0;
                    res_item_next.is_pad_count = 1'b0;
                    res_item_next.last_of_run  = 1'b1;
                    res_item_next.length_error = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sh_reg        <= '0;
            cnt_reg       <= '0;
            pad_reg       <= '0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            cnt_reg       <= cnt_next;
            pad_reg       <= pad_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

// ===== rtl/huffman_code_bit_packer.sv =====
// Static Huffman encoder with a byte packer.
// Input channel (op_valid, op_stall, op_item): a load writes one code table
// entry, an encode appends the code of a symbol, a finish pads the last
// partial byte with zeros and sends the pad count. Output channel
// (res_valid, res_stall, res_item) carries packed bytes MSB first.
// A front stage looks the symbol up in the code table (a registered RAM read)
// and drops commands into a four-entry queue; the back stage takes one command
// and then sends one result per cycle while res_stall is low. An encode sends
// each byte it completes through the back stage's single byte shifter, and the
// back stage takes no new command until those bytes are out. A load with a
// valid length gives no result; one whose length is too long gives an error report.
// Reset clears the table valid bits, so every symbol is unused at once, and
// empties the bit accumulator; no clearing pass follows.
// When the receiver stalls, the output register holds its result, the queue
// fills, and op_stall rises once the queue has no room for new commands.
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_code_bit_packer_macros.svh"

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    output logic                     op_stall,
    input  wire hcbp_pkg::in_item_t  op_item,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output hcbp_pkg::out_item_t      res_item
);

    logic                         q_push;
    logic                         q_pop;
    hcbp_pkg::cmd_t               q_cmd;
    hcbp_pkg::cmd_t               q_head;
    logic [hcbp_pkg::QCNT_W-1:0]  q_count;

    // Front: classification and table access.
    hcbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_stall (op_stall),
        .op_item  (op_item),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // Command queue between the two halves.
    hcbp_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (q_cmd),
        .pop    (q_pop),
        .head   (q_head),
        .count  (q_count)
    );

    // Back: bit accumulation and byte output.
    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_count   (q_count),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // The credit check keeps the queue from overflowing; the back stage pops only when it is not empty.
    `HCBP_ASSERT_SAME(a_queue_no_overflow, q_push && !q_pop,
        q_count < hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH), "command queue overflow")
    `HCBP_ASSERT_SAME(a_queue_no_underflow, q_pop, q_count != '0, "command queue underflow")
    `HCBP_ASSERT_NEXT(a_queue_count_up, q_push && !q_pop,
        q_count == $past(q_count) + 1'b1, "queue count did not follow a push")
    // An error report stands alone as the only result of its transfer.
    `HCBP_ASSERT_SAME(a_error_alone, res_valid && res_item.length_error,
        res_item.last_of_run && !res_item.is_pad_count && (res_item.data_byte == 8'd0),
        "malformed error result")

endmodule

`default_nettype wire
